// ===== src/bisection_root_finder_assert.svh =====
// assertion macros for the bisection root finder checker
`ifndef BISECTION_ROOT_FINDER_ASSERT_SVH
`define BISECTION_ROOT_FINDER_ASSERT_SVH

// same-cycle implication
`define BRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bisection root finder assertion failed");

// next-cycle implication
`define BRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bisection root finder assertion failed");

`endif

// ===== src/brf_pkg.sv =====
`timescale 1ns / 1ps

package brf_pkg;

    localparam int IN_W      = 22;
    localparam int PREC_W    = 30;
    localparam int ITER_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 30;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS   = 16;

    localparam logic [PREC_W-1:0] PRECISION_RST    = PREC_W'(66);
    localparam logic [PREC_W-1:0] MIN_INTERVAL_RST = PREC_W'(66);
    localparam logic [ITER_W-1:0] MAX_ITER_RST     = ITER_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_BRACKET = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ITER_LIMIT  = 2'd2;

    typedef struct packed {
        logic [PREC_W-1:0] precision;
        logic [PREC_W-1:0] min_interval;
        logic [ITER_W-1:0] max_iterations;
    } brf_cfg_t;

endpackage

// ===== src/brf_cfg.sv =====
`timescale 1ns / 1ps

module brf_cfg
    import brf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output brf_cfg_t              cfg
);

    brf_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.precision      <= PRECISION_RST;
            cfg_reg.min_interval   <= MIN_INTERVAL_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRECISION:    cfg_reg.precision      <= cfg_data[PREC_W-1:0];
                CFG_MIN_INTERVAL: cfg_reg.min_interval   <= cfg_data[PREC_W-1:0];
                CFG_MAX_ITER:     cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

// ===== src/brf_mul.sv =====
`timescale 1ns / 1ps

module brf_mul
    import brf_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 22
)
(
    input  logic                      clk,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    output logic signed [A_W+B_W-1:0] p
);

    logic signed [A_W+B_W-1:0] p_reg;

    assign p = p_reg;

    // registered product, one per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

endmodule

// ===== src/brf_ctrl.sv =====
`timescale 1ns / 1ps

module brf_ctrl
    import brf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
    parameter int A_W         = 2 * IN_W - DEFAULT_FRAC_BITS + 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [IN_W-1:0]     bracket_low,
    input  logic signed [IN_W-1:0]     bracket_high,
    input  brf_cfg_t                   cfg,
    output logic signed [A_W-1:0]      mul_a,
    output logic signed [IN_W-1:0]     mul_b,
    input  logic signed [A_W+IN_W-1:0] mul_p,
    output logic                       busy,
    output logic                       done,
    output logic signed [IN_W-1:0]     root,
    output logic [STATUS_W-1:0]        status
);

    localparam int P_W   = A_W + IN_W;
    localparam int F_W   = (P_W > VALUE_WIDTH ? P_W : VALUE_WIDTH) + 2;
    localparam int CMP_W = (VALUE_WIDTH + 1 > PREC_W + 1) ? VALUE_WIDTH + 1 : PREC_W + 1;

    localparam logic signed [F_W-1:0] VAL_MAX =
        {{(F_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [F_W-1:0] VAL_MIN = ~VAL_MAX;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_CUBE, S_FUN, S_DECIDE} state_t;
    typedef enum logic [1:0] {T_LO, T_HI, T_MID} target_t;

    state_t                         state_reg,  state_next;
    target_t                        tgt_reg,    tgt_next;
    logic signed [IN_W-1:0]         lo_reg,     lo_next;
    logic signed [IN_W-1:0]         hi_reg,     hi_next;
    logic signed [IN_W-1:0]         x_reg,      x_next;
    logic signed [VALUE_WIDTH-1:0]  flo_reg,    flo_next;
    logic signed [VALUE_WIDTH-1:0]  f_reg,      f_next;
    logic [ITER_W-1:0]              it_reg,     it_next;
    logic                           done_reg,   done_next;
    logic signed [IN_W-1:0]         root_reg,   root_next;
    logic [STATUS_W-1:0]            status_reg, status_next;

    logic signed [P_W-1:0]    prod_shift;
    logic signed [F_W-1:0]    fval;
    logic signed [F_W-1:0]    fsat;
    logic signed [CMP_W-1:0]  f_ext, flo_ext, abs_f, abs_flo, prec_ext;
    logic signed [PREC_W:0]   width_ext, minw_ext;
    logic signed [IN_W:0]     width;
    logic                     same_sign, bad, keep_lo;
    logic signed [IN_W-1:0]   nlo, nhi;

    function automatic logic signed [IN_W-1:0] mid_of(
        input logic signed [IN_W-1:0] a,
        input logic signed [IN_W-1:0] b
    );
        logic signed [IN_W:0] s;
        s = (IN_W+1)'(a) + (IN_W+1)'(b);
        return s[IN_W:1];
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign root   = root_reg;
    assign status = status_reg;

    // shared multiplier: x*x, then sq*x
    assign prod_shift = mul_p >>> FRAC_BITS;
    assign mul_a = (state_reg == S_CUBE) ? prod_shift[A_W-1:0] : A_W'(x_reg);
    assign mul_b = x_reg;

    // f = -cube + 4x + 1.0, saturated
    always_comb
    begin
        fval = -F_W'(prod_shift) + (F_W'(x_reg) <<< 2) + (F_W'(1) <<< FRAC_BITS);
        if (fval > VAL_MAX)
            fsat = VAL_MAX;
        else if (fval < VAL_MIN)
            fsat = VAL_MIN;
        else
            fsat = fval;
    end

    always_comb
    begin
        f_ext     = CMP_W'(f_reg);
        flo_ext   = CMP_W'(flo_reg);
        abs_f     = f_reg < 0 ? -f_ext : f_ext;
        abs_flo   = flo_reg < 0 ? -flo_ext : flo_ext;
        prec_ext  = CMP_W'({1'b0, cfg.precision});
        width     = (IN_W+1)'(hi_reg) - (IN_W+1)'(lo_reg);
        width_ext = (PREC_W+1)'(width);
        minw_ext  = {1'b0, cfg.min_interval};
        same_sign = (flo_reg > 0 && f_reg > 0) || (flo_reg < 0 && f_reg < 0);
        bad       = same_sign || (cfg.precision == '0) || (cfg.min_interval == '0)
                    || !(lo_reg < hi_reg);
        keep_lo   = (flo_reg < 0) ? (f_reg < 0) : (f_reg > 0);
        nlo       = keep_lo ? x_reg : lo_reg;
        nhi       = keep_lo ? hi_reg : x_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        tgt_next    = tgt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        x_next      = x_reg;
        flo_next    = flo_reg;
        f_next      = f_reg;
        it_next     = it_reg;
        done_next   = 1'b0;
        root_next   = root_reg;
        status_next = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = bracket_low;
                    hi_next    = bracket_high;
                    x_next     = bracket_low;
                    tgt_next   = T_LO;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                state_next = S_FUN;
            end
            S_FUN:
            begin
                f_next     = fsat[VALUE_WIDTH-1:0];
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (tgt_reg)
                    T_LO:
                    begin
                        flo_next   = f_reg;
                        x_next     = hi_reg;
                        tgt_next   = T_HI;
                        state_next = S_SQ;
                    end
                    T_HI:
                    begin
                        if (bad)
                        begin
                            done_next   = 1'b1;
                            root_next   = '0;
                            status_next = STATUS_BAD_BRACKET;
                            state_next  = S_IDLE;
                        end
                        else if (abs_flo <= prec_ext)
                        begin
                            done_next   = 1'b1;
                            root_next   = lo_reg;
                            status_next = STATUS_FOUND;
                            state_next  = S_IDLE;
                        end
                        else if (abs_f <= prec_ext)
                        begin
                            done_next   = 1'b1;
                            root_next   = hi_reg;
                            status_next = STATUS_FOUND;
                            state_next  = S_IDLE;
                        end
                        else if (cfg.max_iterations == '0)
                        begin
                            done_next   = 1'b1;
                            root_next   = '0;
                            status_next = STATUS_ITER_LIMIT;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            it_next    = '0;
                            x_next     = mid_of(lo_reg, hi_reg);
                            tgt_next   = T_MID;
                            state_next = S_SQ;
                        end
                    end
                    T_MID:
                    begin
                        if ((abs_f < prec_ext) || (width_ext < minw_ext))
                        begin
                            done_next   = 1'b1;
                            root_next   = x_reg;
                            status_next = STATUS_FOUND;
                            state_next  = S_IDLE;
                        end
                        else if (({1'b0, it_reg} + (ITER_W+1)'(1)) ==
                                 {1'b0, cfg.max_iterations})
                        begin
                            done_next   = 1'b1;
                            root_next   = '0;
                            status_next = STATUS_ITER_LIMIT;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            lo_next    = nlo;
                            hi_next    = nhi;
                            if (keep_lo)
                                flo_next = f_reg;
                            it_next    = it_reg + ITER_W'(1);
                            x_next     = mid_of(nlo, nhi);
                            state_next = S_SQ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tgt_reg    <= T_LO;
            lo_reg     <= '0;
            hi_reg     <= '0;
            x_reg      <= '0;
            flo_reg    <= '0;
            f_reg      <= '0;
            it_reg     <= '0;
            done_reg   <= 1'b0;
            root_reg   <= '0;
            status_reg <= STATUS_FOUND;
        end
        else
        begin
            state_reg  <= state_next;
            tgt_reg    <= tgt_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            x_reg      <= x_next;
            flo_reg    <= flo_next;
            f_reg      <= f_next;
            it_reg     <= it_next;
            done_reg   <= done_next;
            root_reg   <= root_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== src/bisection_root_finder.sv =====
`timescale 1ns / 1ps
// Bisection root finder for f(x) = -x^3 + 4x + 1 on a signed fixed-point bracket.
// Pulse start while busy is low to transfer a bracket; busy stays high until the
// result. Every cubic evaluation runs on the one shared multiplier through the
// states S_SQ (x*x), S_CUBE (sq*x), S_FUN (add and saturate) and S_DECIDE; the
// low and high ends are evaluated first, then 0 up to max_iterations midpoints.
// The result strobe done is high for exactly one cycle with
// root and status, and cannot be held off: the receiver must take it then.
// A new bracket may be started in the same cycle as done. Configuration writes
// are always ready and must only be made while the block is idle.

module bisection_root_finder
    import brf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEFAULT_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] bracket_low,
    input  logic signed [IN_W-1:0] bracket_high,
    output logic                   done,
    output logic signed [IN_W-1:0] root,
    output logic [STATUS_W-1:0]    status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SQ_W = 2 * IN_W - FRAC_BITS + 1;
    localparam int A_W  = (SQ_W > IN_W) ? SQ_W : IN_W;
    localparam int P_W  = A_W + IN_W;

    brf_cfg_t               cfg;
    logic signed [A_W-1:0]  mul_a;
    logic signed [IN_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;

    brf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brf_mul #(
        .A_W (A_W),
        .B_W (IN_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    brf_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .A_W         (A_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .bracket_low  (bracket_low),
        .bracket_high (bracket_high),
        .cfg          (cfg),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p),
        .busy         (busy),
        .done         (done),
        .root         (root),
        .status       (status)
    );

endmodule

// ===== src/brf_checker.sv =====
`timescale 1ns / 1ps
`include "bisection_root_finder_assert.svh"

module brf_checker
    import brf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic signed [IN_W-1:0] root,
    input logic [STATUS_W-1:0]    status
);

    `BRF_ASSERT_IMP(a_status_legal, clk, rst_n, done, (status == STATUS_FOUND) || (status == STATUS_BAD_BRACKET) || (status == STATUS_ITER_LIMIT))
    `BRF_ASSERT_IMP(a_root_zero_on_fail, clk, rst_n, done && (status != STATUS_FOUND), root == '0)
    `BRF_ASSERT_NXT(a_transfer_busy, clk, rst_n, start && !busy, busy)
    `BRF_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `BRF_ASSERT_IMP(a_done_ends_busy, clk, rst_n, done, $past(busy) && !busy)

endmodule

bind bisection_root_finder brf_checker u_brf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .root   (root),
    .status (status)
);
